// ===== sv/dbp_pkg.sv =====
package dbp_pkg;

	// field widths
	localparam int ROW_CNT_W = 16;
	localparam int ROW_LEN_W = 24;
	localparam int OFF_W     = 48;
	localparam int STRIDE_W  = 32;
	localparam int LIMIT_W   = 9;
	localparam int TOTAL_W   = 32;
	localparam int LG_W      = 3;
	localparam int KIND_W    = 2;

	// widest head (distance from the beat-aligned base), 64-byte beats
	localparam int HEAD_W = 6;
	// burst byte cap: up to 256 beats of 64 bytes
	localparam int CMAX_W = LIMIT_W + HEAD_W;

	localparam logic [LG_W-1:0]    LG_RESET  = 3'd3;
	localparam logic [LG_W-1:0]    LG_MAX    = 3'd6;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX = 9'd256;

	localparam logic FUNC_LOCAL = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD,
		KIND_PREFETCH,
		KIND_STORE,
		KIND_OTHER
	} kind_t;

	typedef struct packed {
		logic                 func;
		logic [KIND_W-1:0]    xfer_kind;
		logic [ROW_CNT_W-1:0] row_count;
		logic [ROW_LEN_W-1:0] row_length;
		logic [OFF_W-1:0]     src_offset;
		logic [STRIDE_W-1:0]  src_stride;
		logic [OFF_W-1:0]     dst_offset;
		logic [STRIDE_W-1:0]  dst_stride;
		logic [LIMIT_W-1:0]   burst_beat_limit;
	} desc_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RECIP,
		ST_PAGE,
		ST_WAIT_PAGE,
		ST_ROW_A,
		ST_ROW_B,
		ST_ROW_C,
		ST_ROW_D,
		ST_ROW_E,
		ST_ROW_F,
		ST_ROW_G,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RECIP,
		OP_PAGE,
		OP_ROW_A,
		OP_ROW_B,
		OP_ROW_C,
		OP_ROW_D,
		OP_ROW_E,
		OP_ROW_F,
		OP_ROW_G
	} op_t;

	typedef struct packed {
		op_t  op;
		logic next_row;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic recip_last;
		logic fits;
		logic last_row;
		logic unit_busy;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/dbp_if.sv =====
interface dbp_desc_if;
	import dbp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [KIND_W-1:0]    xfer_kind;
	logic [ROW_CNT_W-1:0] row_count;
	logic [ROW_LEN_W-1:0] row_length;
	logic [OFF_W-1:0]     src_offset;
	logic [STRIDE_W-1:0]  src_stride;
	logic [OFF_W-1:0]     dst_offset;
	logic [STRIDE_W-1:0]  dst_stride;
	logic [LIMIT_W-1:0]   burst_beat_limit;

	modport source (
		output valid, func, xfer_kind, row_count, row_length, src_offset, src_stride,
		       dst_offset, dst_stride, burst_beat_limit,
		input  ready
	);
	modport sink (
		input  valid, func, xfer_kind, row_count, row_length, src_offset, src_stride,
		       dst_offset, dst_stride, burst_beat_limit,
		output ready
	);
endinterface

interface dbp_result_if;
	import dbp_pkg::*;

	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] burst_total;
	logic [TOTAL_W-1:0] beat_total;

	modport source (output valid, burst_total, beat_total, input ready);
	modport sink (input valid, burst_total, beat_total, output ready);
endinterface

// ===== sv/dbp_ceil_div.sv =====
module dbp_ceil_div #(
	parameter int PAGE_BYTES = 4096,
	localparam int K = $clog2(PAGE_BYTES) + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dbp_pkg::LG_W-1:0]    lg,
	input  logic [dbp_pkg::LIMIT_W-1:0] lim,
	input  logic [K:0]                  recip,
	input  logic                        in_valid,
	input  logic                        in_tag,
	input  logic [K-1:0]                in_x,
	output logic                        out_valid,
	output logic                        out_tag,
	output logic [K-1:0]                out_q,
	output logic                        busy
);
	import dbp_pkg::*;

	// ceil(x / (lim << lg)) = ceil(ceil(x >> lg) / lim), the last one by reciprocal
	localparam int PW = 2 * K + 1;
	localparam int QW = K + LIMIT_W;

	logic [K-1:0]  wmask;
	logic [K-1:0]  y;
	logic [K-1:0]  z;
	logic [PW-1:0] prod;
	logic [QW-1:0] prod_l;
	logic          fix;

	logic          v_s1, v_s2, v_s3, v_s4;
	logic          tag_s1, tag_s2, tag_s3, tag_s4;
	logic [K-1:0]  z_s1, z_s2, z_s3;
	logic [K-1:0]  qe_s2, qe_s3, q_s4;
	logic [QW-1:0] pl_s3;

	assign wmask  = ~({K{1'b1}} << lg);
	assign y      = (in_x + wmask) >> lg;
	assign z      = y + K'(lim) - K'(1);
	assign prod   = PW'(z_s1) * PW'(recip);
	assign prod_l = QW'(qe_s2) * QW'(lim);
	// estimate is exact or one short
	assign fix    = QW'(z_s3) >= pl_s3 + QW'(lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			tag_s1 <= 1'b0;
			tag_s2 <= 1'b0;
			tag_s3 <= 1'b0;
			tag_s4 <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		z_s1  <= z;
		z_s2  <= z_s1;
		qe_s2 <= prod[K +: K];
		z_s3  <= z_s2;
		qe_s3 <= qe_s2;
		pl_s3 <= prod_l;
		q_s4  <= qe_s3 + K'(fix);
	end

	assign out_valid = v_s4;
	assign out_tag   = tag_s4;
	assign out_q     = q_s4;
	assign busy      = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

// ===== sv/dbp_datapath.sv =====
module dbp_datapath #(
	parameter int PAGE_BYTES = 4096,
	localparam int P = $clog2(PAGE_BYTES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dbp_pkg::LG_W-1:0]    cfg_wdata,
	input  dbp_pkg::desc_t              desc,
	input  dbp_pkg::cmd_t               cmd,
	output dbp_pkg::stat_t              st,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [dbp_pkg::TOTAL_W-1:0] burst_total,
	output logic [dbp_pkg::TOTAL_W-1:0] beat_total
);
	import dbp_pkg::*;

	localparam int K    = P + 1;
	localparam int CNTW = $clog2(K + 1);
	localparam int MW   = (K > CMAX_W) ? K : CMAX_W;
	localparam int PRW  = ROW_LEN_W + 1;
	localparam logic [K-1:0] PAGE_K = K'(PAGE_BYTES);

	// item setup
	logic                 use_src;
	logic [LIMIT_W-1:0]   lim_in;
	logic [LG_W-1:0]      lg_sat;
	logic [LG_W-1:0]      bwl_q;

	// per-item registers
	logic [LG_W-1:0]      lg_q;
	logic [LIMIT_W-1:0]   lim_q;
	logic [CMAX_W-1:0]    cmax_q;
	logic [ROW_LEN_W-1:0] len_q;
	logic [P-1:0]         stride_q;
	logic [P-1:0]         a_q;
	logic [ROW_CNT_W-1:0] rows_q;
	logic [K-1:0]         ppb_q;

	// reciprocal of the beat limit, restoring, one quotient bit per cycle
	logic [LIMIT_W-1:0]   rec_rem_q;
	logic [K:0]           rec_quo_q;
	logic [CNTW-1:0]      rec_cnt_q;
	logic [LIMIT_W:0]     rec_sh;
	logic                 rec_ge;

	// per-row registers
	logic [HEAD_W-1:0]    head_q;
	logic [P-1:0]         base_lo_q;
	logic [K-1:0]         cap_q;
	logic [K-1:0]         take_q;
	logic [ROW_LEN_W-1:0] rest_q;
	logic [P-1:0]         next_lo_q;
	logic [K-1:0]         room_q;
	logic [ROW_LEN_W-1:0] rest2_q;
	logic [PRW-1:0]       prod_q;

	logic [TOTAL_W-1:0]   bursts_q, beats_q;
	logic [TOTAL_W-1:0]   burst_total_q, beat_total_q;
	logic                 res_valid_q;

	// row arithmetic
	logic [P-1:0]         wm_p;
	logic [K-1:0]         wm_k;
	logic [ROW_LEN_W:0]   wm_l;
	logic [K-1:0]         pg_rem;
	logic [K-1:0]         cap_d;
	logic [K-1:0]         avail;
	logic [K-1:0]         take_d;
	logic [K-1:0]         add_head;
	logic [ROW_LEN_W:0]   add_rest;
	logic [K-1:0]         seg;
	logic [TOTAL_W-1:0]   inc_add, div_add;

	// shared ceil-divide unit
	logic                 u_in_valid, u_in_tag;
	logic [K-1:0]         u_in_x;
	logic                 u_valid, u_tag, u_busy;
	logic [K-1:0]         u_q;

	assign use_src = (desc.func == FUNC_LOCAL) || (desc.xfer_kind == KIND_LOAD)
	                 || (desc.xfer_kind == KIND_PREFETCH);
	assign lim_in  = (desc.burst_beat_limit == '0) ? LIMIT_W'(1)
	               : (desc.burst_beat_limit > LIMIT_MAX) ? LIMIT_MAX : desc.burst_beat_limit;
	assign lg_sat  = (bwl_q > LG_MAX) ? LG_MAX : bwl_q;

	assign rec_sh  = {rec_rem_q, (rec_cnt_q == '0)};
	assign rec_ge  = rec_sh >= (LIMIT_W + 1)'(lim_q);

	assign wm_p     = ~({P{1'b1}} << lg_q);
	assign wm_k     = ~({K{1'b1}} << lg_q);
	assign wm_l     = ~({(ROW_LEN_W + 1){1'b1}} << lg_q);
	assign pg_rem   = PAGE_K - K'(a_q & ~wm_p);
	assign cap_d    = (MW'(cmax_q) < MW'(pg_rem)) ? K'(cmax_q) : pg_rem;
	assign avail    = cap_q - K'(head_q);
	assign take_d   = (ROW_LEN_W'(avail) > len_q) ? K'(len_q) : avail;
	assign add_head = (K'(head_q) + take_q + wm_k) >> lg_q;
	assign add_rest = ((ROW_LEN_W + 1)'(rest_q) + wm_l) >> lg_q;
	assign seg      = (ROW_LEN_W'(room_q) < rest_q) ? room_q : K'(rest_q);

	always_comb begin
		u_in_valid = 1'b0;
		u_in_tag   = 1'b0;
		u_in_x     = PAGE_K;
		unique case (cmd.op)
			OP_PAGE: begin
				u_in_valid = 1'b1;
				u_in_tag   = 1'b1;
			end
			OP_ROW_E: begin
				u_in_valid = 1'b1;
				u_in_x     = seg;
			end
			OP_ROW_F: begin
				u_in_valid = 1'b1;
				u_in_x     = K'(rest2_q[P-1:0]);
			end
			default: begin
			end
		endcase
	end

	assign inc_add = (cmd.op == OP_ROW_C) ? TOTAL_W'(1)
	               : (cmd.op == OP_ROW_G) ? TOTAL_W'(prod_q) : '0;
	assign div_add = (u_valid && !u_tag) ? TOTAL_W'(u_q) : '0;

	dbp_ceil_div #(.PAGE_BYTES(PAGE_BYTES)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.lg       (lg_q),
		.lim      (lim_q),
		.recip    (rec_quo_q),
		.in_valid (u_in_valid),
		.in_tag   (u_in_tag),
		.in_x     (u_in_x),
		.out_valid(u_valid),
		.out_tag  (u_tag),
		.out_q    (u_q),
		.busy     (u_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bwl_q       <= LG_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bwl_q <= cfg_wdata;
			end
			if (cmd.publish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			lg_q      <= lg_sat;
			lim_q     <= lim_in;
			cmax_q    <= CMAX_W'(lim_in) << lg_sat;
			len_q     <= desc.row_length;
			rows_q    <= desc.row_count;
			a_q       <= use_src ? desc.src_offset[P-1:0] : desc.dst_offset[P-1:0];
			stride_q  <= use_src ? desc.src_stride[P-1:0] : desc.dst_stride[P-1:0];
			rec_rem_q <= '0;
			rec_cnt_q <= '0;
			bursts_q  <= '0;
			beats_q   <= '0;
		end else begin
			bursts_q <= bursts_q + inc_add + div_add;
			if (cmd.op == OP_ROW_C) begin
				beats_q <= beats_q + TOTAL_W'(add_head);
			end else if (cmd.op == OP_ROW_D) begin
				beats_q <= beats_q + TOTAL_W'(add_rest);
			end
			if (cmd.op == OP_RECIP) begin
				rec_rem_q <= rec_ge ? LIMIT_W'(rec_sh - (LIMIT_W + 1)'(lim_q))
				                    : LIMIT_W'(rec_sh);
				rec_quo_q <= {rec_quo_q[K-1:0], rec_ge};
				rec_cnt_q <= rec_cnt_q + CNTW'(1);
			end
			if (cmd.next_row) begin
				a_q    <= a_q + stride_q;
				rows_q <= rows_q - ROW_CNT_W'(1);
			end
		end

		if (u_valid && u_tag) begin
			ppb_q <= u_q;
		end

		// first burst of the row
		if (cmd.op == OP_ROW_A) begin
			head_q    <= HEAD_W'(a_q & wm_p);
			base_lo_q <= a_q & ~wm_p;
			cap_q     <= cap_d;
		end
		if (cmd.op == OP_ROW_B) begin
			take_q <= take_d;
		end
		if (cmd.op == OP_ROW_C) begin
			rest_q    <= len_q - ROW_LEN_W'(take_q);
			next_lo_q <= base_lo_q + P'(cap_q);
		end
		// remainder: rest of the page, whole pages, tail
		if (cmd.op == OP_ROW_D) begin
			room_q <= PAGE_K - K'(next_lo_q);
		end
		if (cmd.op == OP_ROW_E) begin
			rest2_q <= rest_q - ROW_LEN_W'(seg);
		end
		if (cmd.op == OP_ROW_F) begin
			prod_q <= PRW'(rest2_q[ROW_LEN_W-1:P]) * PRW'(ppb_q);
		end

		if (cmd.publish) begin
			burst_total_q <= bursts_q;
			beat_total_q  <= beats_q;
		end
	end

	assign st.empty      = (rows_q == '0) || (len_q == '0);
	assign st.recip_last = rec_cnt_q == CNTW'(K);
	assign st.fits       = ROW_LEN_W'(take_q) == len_q;
	assign st.last_row   = rows_q == ROW_CNT_W'(1);
	assign st.unit_busy  = u_busy;
	assign st.out_free   = !res_valid_q || res_ready;

	assign res_valid   = res_valid_q;
	assign burst_total = burst_total_q;
	assign beat_total  = beat_total_q;

endmodule

// ===== sv/dbp_ctrl.sv =====
module dbp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            desc_valid,
	output logic            desc_ready,
	input  dbp_pkg::stat_t  st,
	output dbp_pkg::cmd_t   cmd
);
	import dbp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.next_row = 1'b0;
		cmd.publish  = 1'b0;
		desc_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				desc_ready = 1'b1;
				if (desc_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_RECIP;
				end
			end
			ST_RECIP: begin
				cmd.op = OP_RECIP;
				priority if (st.empty) begin
					state_d = ST_FINISH;
				end else if (st.recip_last) begin
					state_d = ST_PAGE;
				end
			end
			ST_PAGE: begin
				cmd.op  = OP_PAGE;
				state_d = ST_WAIT_PAGE;
			end
			ST_WAIT_PAGE: begin
				if (!st.unit_busy) begin
					state_d = ST_ROW_A;
				end
			end
			ST_ROW_A: begin
				cmd.op  = OP_ROW_A;
				state_d = ST_ROW_B;
			end
			ST_ROW_B: begin
				cmd.op  = OP_ROW_B;
				state_d = ST_ROW_C;
			end
			ST_ROW_C: begin
				cmd.op = OP_ROW_C;
				if (st.fits) begin
					cmd.next_row = 1'b1;
					state_d      = st.last_row ? ST_FINISH : ST_ROW_A;
				end else begin
					state_d = ST_ROW_D;
				end
			end
			ST_ROW_D: begin
				cmd.op  = OP_ROW_D;
				state_d = ST_ROW_E;
			end
			ST_ROW_E: begin
				cmd.op  = OP_ROW_E;
				state_d = ST_ROW_F;
			end
			ST_ROW_F: begin
				cmd.op  = OP_ROW_F;
				state_d = ST_ROW_G;
			end
			ST_ROW_G: begin
				cmd.op       = OP_ROW_G;
				cmd.next_row = 1'b1;
				state_d      = st.last_row ? ST_FINISH : ST_ROW_A;
			end
			ST_FINISH: begin
				if (!st.unit_busy && st.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/dma_burst_planner_top.sv =====
// Sequence: an empty descriptor goes from accept straight to its result; otherwise
//   setup (reciprocal of the beat limit, page burst count), then the first-burst steps
//   for each row, plus the remainder steps for a row that does not fit its first burst,
//   then the divide unit drains; a stalled output adds its stall.
// Throughput: one descriptor at a time; the next is taken while a result waits in the out reg.
// Reset: async, active low; returns to idle, no result pending, beat width back to 8 bytes.
module dma_burst_planner_top #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [dbp_pkg::LG_W-1:0] cfg_wdata,
	dbp_desc_if.sink                 desc,
	dbp_result_if.source             result
);
	import dbp_pkg::*;

	// Each row is split as the bus sees it: a first burst from the beat-aligned base,
	// capped by the page end and by limit*width bytes, then the rest of that page, then
	// whole pages, then a tail. Beats are counted with shifts; the burst count of each
	// piece is a ceiling divide by limit*width, done by a pipelined reciprocal unit.
	// Only the low page bits of a row address matter, so the row address is kept
	// modulo the page and advanced by the stride each row.

	desc_t desc_w;
	cmd_t  cmd;
	stat_t st;
	logic  ready_w;

	// descriptor beat payload, gathered into one word
	assign desc_w.func             = desc.func;
	assign desc_w.xfer_kind        = desc.xfer_kind;
	assign desc_w.row_count        = desc.row_count;
	assign desc_w.row_length       = desc.row_length;
	assign desc_w.src_offset       = desc.src_offset;
	assign desc_w.src_stride       = desc.src_stride;
	assign desc_w.dst_offset       = desc.dst_offset;
	assign desc_w.dst_stride       = desc.dst_stride;
	assign desc_w.burst_beat_limit = desc.burst_beat_limit;

	// ready only in idle; the controller loads the datapath on the accepted beat
	assign desc.ready = ready_w;

	dbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc.valid),
		.desc_ready(ready_w),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath owns the width register and the result register
	dbp_datapath #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.desc       (desc_w),
		.cmd        (cmd),
		.st         (st),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.burst_total(result.burst_total),
		.beat_total (result.beat_total)
	);

endmodule
